>>> hw/rtl/masked_byte_signature_matcher_assert.svh
// Assertion macros for the masked byte signature matcher.
// Used by the top level only; expects clk_i and rst_ni in the including scope.
`ifndef MASKED_BYTE_SIGNATURE_MATCHER_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_MATCHER_ASSERT_SVH

// Checked property, off while reset is asserted.
`define MSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked implication, off while reset is asserted.
`define MSM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/msm_pkg.sv
// Shared types and constants of the masked byte signature matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msm_pkg;

  localparam int PAT_BYTES = 32;  // pattern storage in the register file
  localparam int PAT_IDX_W = 5;   // index into the pattern bytes
  localparam int LEN_W     = 6;   // pattern_length register
  localparam int POS_W     = 32;  // stream positions
  localparam int OFS_W     = 8;   // report_offset register
  localparam int CFG_W     = 64;  // widest configuration register
  localparam int CFG_IDX_W = 3;   // configuration register index
  localparam int WORD_CNT  = 4;   // 64-bit pattern words

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_CMP_EN    = 3'd4,
    REG_PAT_LEN   = 3'd5,
    REG_OFFSET    = 3'd6
  } msm_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } msm_in_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_start;
    logic [POS_W-1:0] patch_position;
  } msm_out_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;
    logic clear;
  } msm_cell_ctl_t;

  // Pattern byte aligned to a cell for the current length.
  typedef struct packed {
    logic [7:0] pat_byte;
    logic       cmp_en;
    logic       active;
  } msm_cell_pat_t;

endpackage

>>> hw/rtl/masked_byte_signature_matcher.sv
// Channel | Direction | Beat                              | Handshake
// in      | input     | msm_in_t  (data_byte, restart)    | in_valid_i / in_stall_o
// out     | output    | msm_out_t (match, start, patch)   | out_valid_o / out_stall_i
// cfg     | input     | cfg_idx_i, cfg_wdata_i            | cfg_we_i, no wait
//
// One input beat is taken per cycle while in_stall_o is low; its result is registered in
// the output register or skid entry. The rate is set by the compare across the chain of
// window cells, which all check their byte in parallel in the cycle the beat is accepted.
// Reset clears the cell fill flags, the stream position and the configuration; there
// is no clearing pass. A stalled output keeps one more result in a skid entry, and
// in_stall_o rises only while that entry is occupied.
// Depends on msm_pkg, msm_cell, msm_out_buf and the assertion macro header.
`timescale 1ns / 1ps

module masked_byte_signature_matcher import msm_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Stream input.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  msm_in_t              in_data_i,
  // Result output.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output msm_out_t             out_data_o,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Only the first 32 pattern bytes exist, so the window never needs more cells.
  localparam int CellCnt = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;

  // Configuration registers.
  logic [CFG_W-1:0]     pat_words_q [WORD_CNT];
  logic [PAT_BYTES-1:0] cmp_en_q;
  logic [LEN_W-1:0]     pat_len_q;
  logic [OFS_W-1:0]     ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WORD_CNT; w++) begin
        pat_words_q[w] <= '0;
      end
      cmp_en_q  <= '0;
      pat_len_q <= LEN_W'(1);
      ofs_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAT_0_7:   pat_words_q[0] <= cfg_wdata_i;
        REG_PAT_8_15:  pat_words_q[1] <= cfg_wdata_i;
        REG_PAT_16_23: pat_words_q[2] <= cfg_wdata_i;
        REG_PAT_24_31: pat_words_q[3] <= cfg_wdata_i;
        REG_CMP_EN:    cmp_en_q       <= cfg_wdata_i[PAT_BYTES-1:0];
        REG_PAT_LEN:   pat_len_q      <= cfg_wdata_i[LEN_W-1:0];
        REG_OFFSET:    ofs_q          <= cfg_wdata_i[OFS_W-1:0];
        default: ;  // Unknown index: the write is dropped.
      endcase
    end
  end

  // Pattern bytes unpacked from the four words.
  logic [7:0] pat_bytes [PAT_BYTES];

  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      pat_bytes[i] = pat_words_q[i / 8][8 * (i % 8) +: 8];
    end
  end

  // A length of zero counts as one, and a length beyond the window is clamped to it.
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    if (pat_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(CellCnt)) begin
      eff_len = LEN_W'(CellCnt);
    end else begin
      eff_len = pat_len_q;
    end
  end

  logic in_fire;
  logic buf_full;

  assign in_fire    = in_valid_i & ~buf_full;
  assign in_stall_o = buf_full;

  // The chain of cells. Cell 0 holds the newest byte; every accepted beat moves each
  // byte one cell further along. For a pattern of length L, cell k lines up with
  // pattern byte L-1-k, and cells at or beyond L take no part in the compare.
  logic [7:0]    cell_byte  [CellCnt];
  logic          cell_valid [CellCnt];
  logic [CellCnt-1:0] cell_hit;

  for (genvar k = 0; k < CellCnt; k++) begin : g_cell
    msm_cell_ctl_t    ctl;
    msm_cell_pat_t    pat;
    logic [LEN_W-1:0] idx_full;
    logic [7:0]       chain_byte;
    logic             chain_valid;

    assign idx_full = eff_len - LEN_W'(k + 1);

    always_comb begin
      ctl.shift    = in_fire;
      // A restart empties the window; only the byte arriving with it survives.
      ctl.clear    = (k != 0) & in_data_i.restart;
      pat.active   = LEN_W'(k) < eff_len;
      pat.pat_byte = pat_bytes[idx_full[PAT_IDX_W-1:0]];
      pat.cmp_en   = cmp_en_q[idx_full[PAT_IDX_W-1:0]];
    end

    if (k == 0) begin : g_head
      assign chain_byte  = in_data_i.data_byte;
      assign chain_valid = 1'b1;
    end else begin : g_body
      assign chain_byte  = cell_byte[k-1];
      assign chain_valid = cell_valid[k-1];
    end

    msm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .pat_i   (pat),
      .byte_i  (chain_byte),
      .valid_i (chain_valid),
      .byte_o  (cell_byte[k]),
      .valid_o (cell_valid[k]),
      .hit_o   (cell_hit[k])
    );
  end

  // Stream position of the byte being taken; a restart numbers it zero.
  logic [POS_W-1:0] bytes_seen_q, bytes_seen_d;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] patch_pos;
  logic             hit;
  msm_out_t         new_out;

  assign cur_pos      = in_data_i.restart ? '0 : bytes_seen_q;
  assign bytes_seen_d = cur_pos + POS_W'(1);
  assign start_pos    = cur_pos - POS_W'(eff_len) + POS_W'(1);
  assign patch_pos    = start_pos + POS_W'(ofs_q);
  assign hit          = &cell_hit;

  always_comb begin
    new_out.match_found    = hit;
    new_out.match_start    = hit ? start_pos : '0;
    new_out.patch_position = hit ? patch_pos : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
    end else if (in_fire) begin
      bytes_seen_q <= bytes_seen_d;
    end
  end

  msm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (new_out),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Checks. A beat without a match must carry zero positions, and a restart beat can
  // only match when the pattern is a single byte long.
  logic out_nomatch;
  logic out_pos_zero;
  logic restart_chk;

  assign out_nomatch  = out_valid_o & ~out_data_o.match_found;
  assign out_pos_zero = (out_data_o.match_start == '0) & (out_data_o.patch_position == '0);
  assign restart_chk  = in_fire & in_data_i.restart & (eff_len != LEN_W'(1));

  `include "masked_byte_signature_matcher_assert.svh"

  `MSM_ASSERT_IMPLY(a_skid_behind_out, buf_full, out_valid_o, "skid entry used with empty output")
  `MSM_ASSERT_IMPLY(a_nomatch_zero, out_nomatch, out_pos_zero, "no-match beat carries a position")
  `MSM_ASSERT_IMPLY(a_restart_short, restart_chk, !hit, "match before window filled")

endmodule

>>> hw/rtl/msm_cell.sv
// One window cell: holds a stream byte and its fill flag, compares against a pattern byte.
// Depends on msm_pkg.
`timescale 1ns / 1ps

module msm_cell import msm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msm_cell_ctl_t ctl_i,
  input  msm_cell_pat_t pat_i,
  input  logic [7:0]    byte_i,
  input  logic          valid_i,
  output logic [7:0]    byte_o,
  output logic          valid_o,
  output logic          hit_o
);

  logic [7:0] byte_q;
  logic       valid_q;
  logic       valid_d;

  // The compare looks at the value the cell takes on this shift.
  assign valid_d = valid_i & ~ctl_i.clear;
  assign hit_o   = ~pat_i.active |
                   (valid_d & (~pat_i.cmp_en | (pat_i.pat_byte == byte_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

>>> hw/rtl/msm_out_buf.sv
// Output register with one skid entry for the result channel.
// Depends on msm_pkg.
`timescale 1ns / 1ps

module msm_out_buf import msm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  msm_out_t push_data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output msm_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  msm_out_t out_data_q, out_data_d;
  msm_out_t skid_data_q, skid_data_d;
  logic     out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q | push_i;
      out_data_d   = skid_valid_q ? skid_data_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
